FILE: design/mbps_pkg.sv
// Package for the masked byte pattern search block.
// Holds sizes, request codes and the types shared by the cell row and the top level.
// No dependencies.
package mbps_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int OFFSET_W    = 48;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

  // request codes carried in req_type
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_BUFFER = 2'd2;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] mask;
  } pair_t;

  // per-transfer controls broadcast to every cell
  typedef struct packed {
    logic clear;
    logic append;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: design/mbps_in_if.sv
// Input channel of the masked byte pattern search block.
// Valid/ready handshake with the request payload; no package dependency.
interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] byte_value;
  logic [7:0] byte_mask;
  logic       last_byte;

  modport source (output valid, req_type, byte_value, byte_mask, last_byte, input ready);
  modport sink   (input valid, req_type, byte_value, byte_mask, last_byte, output ready);
endinterface

FILE: design/mbps_out_if.sv
// Result channel of the masked byte pattern search block.
// Valid/ready handshake carrying found and match_offset; no package dependency.
interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [47:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink   (input valid, found, match_offset, output ready);
endinterface

FILE: design/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search block: cell row, counters, result register.
// Depends on mbps_pkg, mbps_in_if, mbps_out_if and mbps_cell.
//
//   channel | dir | payload                                   | handshake
//   in_if   | in  | req_type, byte_value, byte_mask, last_byte | valid/ready
//   out_if  | out | found, match_offset                       | valid/ready
//
// One request per cycle; the whole window is compared by the cell row as the byte shifts in.
// A result appears in the output register the cycle after its byte transfers.
// in_if.ready is high whenever the output register is empty or draining; else requests wait.
// Synchronous active-low reset empties the pattern and the buffer state; no clearing pass.
module masked_byte_pattern_search (
  input  logic clk,
  input  logic rst_n,
  mbps_in_if.sink    in_if,
  mbps_out_if.source out_if
);

  localparam int N = mbps_pkg::MAX_PATTERN;

  logic [7:0]           byte_c  [0:N];
  mbps_pkg::pair_t      pair_c  [0:N];
  logic                 valid_c [0:N];
  logic [N-1:0]         hit_vec;
  logic [N-1:0]         valid_vec;
  mbps_pkg::cell_ctrl_t ctrl;

  logic [mbps_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [mbps_pkg::OFFSET_W-1:0] seen_r, seen_nxt, seen_inc, len_ext, offset_calc;
  logic                          resolved_r, resolved_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          found_r, found_nxt;
  logic [mbps_pkg::OFFSET_W-1:0] offset_r, offset_nxt;

  logic accept, is_buf, active, full, hit, emit;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign is_buf      = accept && (in_if.req_type == mbps_pkg::REQ_BUFFER);
  assign active      = is_buf && !resolved_r;
  assign full        = valid_c[N];

  assign ctrl.clear  = accept && (in_if.req_type == mbps_pkg::REQ_CLEAR);
  assign ctrl.append = accept && (in_if.req_type == mbps_pkg::REQ_APPEND) && !full;
  assign ctrl.shift  = active;

  // newest pair enters cell 0, so cell k holds pattern entry len-1-k
  assign byte_c[0]        = in_if.byte_value;
  assign pair_c[0].value  = in_if.byte_value;
  assign pair_c[0].mask   = in_if.byte_mask;
  assign valid_c[0]       = 1'b1;

  for (genvar k = 0; k < N; k++) begin : g_cell
    mbps_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .byte_i  (byte_c[k]),
      .pair_i  (pair_c[k]),
      .valid_i (valid_c[k]),
      .byte_o  (byte_c[k+1]),
      .pair_o  (pair_c[k+1]),
      .valid_o (valid_c[k+1]),
      .hit_o   (hit_vec[k])
    );
    assign valid_vec[k] = valid_c[k+1];
  end

  always_comb begin
    seen_inc    = (seen_r == mbps_pkg::OFFSET_MAX) ? seen_r
                                                   : seen_r + mbps_pkg::OFFSET_W'(1);
    len_ext     = mbps_pkg::OFFSET_W'(len_r);
    offset_calc = seen_inc - len_ext;
    hit         = (len_r == '0) || ((seen_inc >= len_ext) && (&hit_vec));
    emit        = active && (hit || in_if.last_byte);

    len_nxt = len_r;
    if (ctrl.clear) begin
      len_nxt = '0;
    end else if (ctrl.append) begin
      len_nxt = len_r + mbps_pkg::LEN_W'(1);
    end

    seen_nxt     = seen_r;
    resolved_nxt = resolved_r;
    if (is_buf) begin
      if (in_if.last_byte) begin
        seen_nxt     = '0;
        resolved_nxt = 1'b0;
      end else if (!resolved_r) begin
        seen_nxt     = seen_inc;
        resolved_nxt = hit;
      end
    end

    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    offset_nxt    = offset_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      found_nxt     = hit;
      offset_nxt    = (hit && (len_r != '0)) ? offset_calc : '0;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      seen_r      <= '0;
      resolved_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      seen_r      <= seen_nxt;
      resolved_r  <= resolved_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    offset_r <= offset_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.found        = found_r;
  assign out_if.match_offset = offset_r;

  // length counter tracks the occupied cells
  a_len_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    len_r == mbps_pkg::LEN_W'($countones(valid_vec)))
    else $error("pattern length disagrees with occupied cells");

  // occupied cells form an unbroken run from cell 0
  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & ~{valid_vec[N-2:0], 1'b1}) == '0)
    else $error("gap in the occupied cells");

  // not found always reports offset zero
  a_miss_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |-> (offset_r == '0))
    else $error("miss carries a non-zero offset");

  // the final byte of a buffer readies the next one
  a_buffer_end: assert property (@(posedge clk) disable iff (!rst_n)
    (is_buf && in_if.last_byte) |=> (!resolved_r && (seen_r == '0)))
    else $error("buffer state not cleared after final byte");

  // a result is only loaded into an empty or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> ($stable(found_r) && $stable(offset_r)))
    else $error("pending result overwritten");

endmodule

FILE: design/mbps_cell.sv
// One cell of the pattern row: a history byte, a pattern pair and its valid bit.
// Bytes and pairs both shift one cell onward; depends on mbps_pkg.
module mbps_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  mbps_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          byte_i,
  input  mbps_pkg::pair_t     pair_i,
  input  logic                valid_i,
  output logic [7:0]          byte_o,
  output mbps_pkg::pair_t     pair_o,
  output logic                valid_o,
  output logic                hit_o
);

  logic [7:0]      byte_r;
  mbps_pkg::pair_t pair_r;
  logic            valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.clear) begin
      valid_r <= 1'b0;
    end else if (ctrl.append) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_r <= byte_i;
    end
    if (ctrl.append) begin
      pair_r <= pair_i;
    end
  end

  // compare against the byte about to land here; empty cells always agree
  assign hit_o   = !valid_r || ((byte_i & pair_r.mask) == (pair_r.value & pair_r.mask));
  assign byte_o  = byte_r;
  assign pair_o  = pair_r;
  assign valid_o = valid_r;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for masked_byte_pattern_search: directed and random traffic.
// A local model predicts every result. Depends on mbps_pkg, mbps_in_if and mbps_out_if.
module tb_top;

  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          HOLD_CYCLES  = 80;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;

  typedef struct packed {
    logic                          found;
    logic [mbps_pkg::OFFSET_W-1:0] offset;
  } match_result_t;

  logic clk;
  logic rst_n;

  mbps_in_if  in_ch ();
  mbps_out_if out_ch ();

  masked_byte_pattern_search u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // search model state
  logic [7:0] pat_val    [mbps_pkg::MAX_PATTERN] = '{default: 8'h00};
  logic [7:0] pat_msk    [mbps_pkg::MAX_PATTERN] = '{default: 8'h00};
  int         pat_len                            = 0;
  logic [7:0] recent_win [mbps_pkg::MAX_PATTERN] = '{default: 8'h00};
  logic [mbps_pkg::OFFSET_W-1:0] bytes_in_buffer = '0;
  bit                            buffer_done     = 1'b0;

  match_result_t expected_matches [$];
  int            errors      = 0;
  int            items_sent  = 0;
  int            cycle_count = 0;
  bit            gaps_on     = 1'b1;
  bit            stalls_on   = 1'b1;
  bit            hold_req    = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void predict_search(input logic [1:0] req, input logic [7:0] val,
                                         input logic [7:0] msk, input logic last,
                                         output bit produced, output match_result_t res);
    bit hit;
    produced = 1'b0;
    res      = '0;
    hit      = 1'b0;
    case (req)
      mbps_pkg::REQ_CLEAR: begin
        for (int i = 0; i < mbps_pkg::MAX_PATTERN; i++) begin
          pat_val[i] = 8'h00;
          pat_msk[i] = 8'h00;
        end
        pat_len = 0;
      end
      mbps_pkg::REQ_APPEND: begin
        if (pat_len < mbps_pkg::MAX_PATTERN) begin
          pat_val[pat_len] = val;
          pat_msk[pat_len] = msk;
          pat_len++;
        end
      end
      mbps_pkg::REQ_BUFFER: begin
        if (buffer_done) begin
          // rest of a matched buffer is dropped until its final byte
          if (last) begin
            bytes_in_buffer = '0;
            buffer_done     = 1'b0;
          end
        end else begin
          for (int i = mbps_pkg::MAX_PATTERN - 1; i > 0; i--) recent_win[i] = recent_win[i-1];
          recent_win[0] = val;
          if (bytes_in_buffer != mbps_pkg::OFFSET_MAX) bytes_in_buffer++;
          if (pat_len == 0) begin
            hit = 1'b1;
          end else if (bytes_in_buffer >= pat_len) begin
            hit = 1'b1;
            for (int j = 0; j < pat_len; j++) begin
              if (((recent_win[pat_len-1-j] ^ pat_val[j]) & pat_msk[j]) != 8'h00) hit = 1'b0;
            end
            if (hit) res.offset = bytes_in_buffer - pat_len;
          end
          if (hit) begin
            produced  = 1'b1;
            res.found = 1'b1;
            if (last) bytes_in_buffer = '0;
            else buffer_done = 1'b1;
          end else if (last) begin
            produced        = 1'b1;
            bytes_in_buffer = '0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(input logic [1:0] req, input logic [7:0] val,
                          input logic [7:0] msk, input logic last);
    bit            produced;
    match_result_t res;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.byte_value <= val;
    in_ch.byte_mask  <= msk;
    in_ch.last_byte  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_search(req, val, msk, last, produced, res);
    if (produced) expected_matches.push_back(res);
    items_sent++;
  endtask

  // sender goes quiet until every outstanding result has been transferred
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);
  endtask

  // one buffer; optionally plants the held pattern with random wildcard bits
  task automatic send_buffer(input int len, input bit plant);
    logic [7:0] stream_bytes [];
    int         pos;
    stream_bytes = new[len];
    foreach (stream_bytes[i]) stream_bytes[i] = 8'($urandom);
    if (plant && pat_len > 0 && pat_len <= len) begin
      pos = $urandom_range(0, len - pat_len);
      for (int j = 0; j < pat_len; j++)
        stream_bytes[pos+j] = (pat_val[j] & pat_msk[j]) | (8'($urandom) & ~pat_msk[j]);
    end
    foreach (stream_bytes[i]) begin
      if ($urandom_range(0, 15) == 0)
        send_req(REQ_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 23) == 0)
        send_req(mbps_pkg::REQ_APPEND, 8'($urandom), 8'($urandom), 1'b0);
      send_req(mbps_pkg::REQ_BUFFER, stream_bytes[i], 8'($urandom), i == len - 1);
    end
  endtask

  task automatic test_directed();
    // empty pattern hits on the first byte; the rest of the buffer is silent
    send_req(mbps_pkg::REQ_BUFFER, 8'h00, 8'hFF, 1'b0);
    send_req(REQ_UNUSED, 8'hFF, 8'hFF, 1'b1);
    send_req(mbps_pkg::REQ_BUFFER, 8'hFF, 8'h00, 1'b1);
    // exact, all-wildcard and nibble-masked pairs
    send_req(mbps_pkg::REQ_APPEND, 8'hFF, 8'hFF, 1'b0);
    send_req(mbps_pkg::REQ_APPEND, 8'h00, 8'h00, 1'b1);
    send_req(mbps_pkg::REQ_APPEND, 8'hA5, 8'h0F, 1'b0);
    send_req(mbps_pkg::REQ_BUFFER, 8'h00, 8'h00, 1'b0);
    send_req(mbps_pkg::REQ_BUFFER, 8'hFF, 8'h00, 1'b0);
    send_req(mbps_pkg::REQ_BUFFER, 8'h12, 8'h00, 1'b0);
    send_req(mbps_pkg::REQ_BUFFER, 8'h35, 8'h00, 1'b0);
    send_req(mbps_pkg::REQ_BUFFER, 8'hFF, 8'h00, 1'b1);
    // buffer shorter than the pattern
    send_req(mbps_pkg::REQ_BUFFER, 8'hFF, 8'h00, 1'b1);
    // match landing on the final byte
    send_req(mbps_pkg::REQ_BUFFER, 8'hFF, 8'h00, 1'b0);
    send_req(mbps_pkg::REQ_BUFFER, 8'h00, 8'h00, 1'b0);
    send_req(mbps_pkg::REQ_BUFFER, 8'h05, 8'h00, 1'b1);
    // pattern grows mid-buffer, history kept
    send_req(mbps_pkg::REQ_CLEAR, 8'hFF, 8'hFF, 1'b1);
    send_req(mbps_pkg::REQ_APPEND, 8'h80, 8'h80, 1'b0);
    send_req(mbps_pkg::REQ_BUFFER, 8'h7F, 8'h00, 1'b0);
    send_req(mbps_pkg::REQ_APPEND, 8'h01, 8'h01, 1'b0);
    send_req(mbps_pkg::REQ_BUFFER, 8'h81, 8'h00, 1'b0);
    send_req(mbps_pkg::REQ_BUFFER, 8'h01, 8'h00, 1'b0);
    send_req(mbps_pkg::REQ_BUFFER, 8'h55, 8'h00, 1'b1);
    drain_results();
  endtask

  task automatic test_full_pattern();
    send_req(mbps_pkg::REQ_CLEAR, 8'h00, 8'h00, 1'b0);
    // two pairs beyond capacity are dropped
    for (int k = 0; k < mbps_pkg::MAX_PATTERN + 2; k++)
      send_req(mbps_pkg::REQ_APPEND, 8'($urandom),
               ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom), 1'($urandom));
    send_buffer(mbps_pkg::MAX_PATTERN + 6, 1'b1);
    send_buffer(40, 1'b1);
    send_buffer(mbps_pkg::MAX_PATTERN, 1'b1);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    send_req(mbps_pkg::REQ_CLEAR, 8'h00, 8'h00, 1'b0);
    hold_req = 1'b1;
    repeat (30) send_req(mbps_pkg::REQ_BUFFER, 8'($urandom), 8'($urandom), 1'b1);
    drain_results();
  endtask

  task automatic test_random_traffic(input int target);
    int plen;
    int nbuf;
    int len;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8))
          send_req(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        send_req(mbps_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(7, mbps_pkg::MAX_PATTERN + 2)
                                            : $urandom_range(0, 6);
        for (int k = 0; k < plen; k++) begin
          case ($urandom_range(0, 3))
            0:       send_req(mbps_pkg::REQ_APPEND, 8'($urandom), 8'hFF, 1'($urandom));
            1:       send_req(mbps_pkg::REQ_APPEND, 8'($urandom), 8'h00, 1'($urandom));
            default: send_req(mbps_pkg::REQ_APPEND, 8'($urandom), 8'($urandom), 1'($urandom));
          endcase
        end
        nbuf = $urandom_range(1, 4);
        for (int b = 0; b < nbuf; b++) begin
          len = (plen > 24) ? $urandom_range(plen - 4, plen + 10) : $urandom_range(1, 24);
          send_buffer(len, $urandom_range(0, 3) != 0);
        end
      end
    end
  endtask

  // result side ready: random stall bursts, one long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    match_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_matches.size() == 0) begin
        $error("unexpected result: found=%0b match_offset=%0d",
               out_ch.found, out_ch.match_offset);
        errors++;
      end else begin
        want = expected_matches.pop_front();
        if (out_ch.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_ch.found);
          errors++;
        end
        if (out_ch.match_offset !== want.offset) begin
          $error("match_offset: expected %0d, got %0d", want.offset, out_ch.match_offset);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= mbps_pkg::REQ_CLEAR;
    in_ch.byte_value <= 8'h00;
    in_ch.byte_mask  <= 8'h00;
    in_ch.last_byte  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_pattern();
    test_output_backpressure();
    test_random_traffic(1600);
    drain_results();
    // final stretch at full rate on both sides
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_traffic(1800);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
